/* design/stack_machine_core_words_assert.svh */
// assertion macros for the stack machine core
`ifndef STACK_MACHINE_CORE_WORDS_ASSERT_SVH
`define STACK_MACHINE_CORE_WORDS_ASSERT_SVH
`ifndef ASSERT_OFF
`define SMCW_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SMCW_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SMCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SMCW_ASSERT_ALWAYS(label, cond, msg)
`define SMCW_ASSERT_IMPLY(label, ante, cons, msg)
`define SMCW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* design/smcw_pkg.sv */
`timescale 1ns / 1ps
package smcw_pkg;

    localparam logic [4:0] CMD_STORE  = 5'd0;
    localparam logic [4:0] CMD_MUL    = 5'd1;
    localparam logic [4:0] CMD_ADD    = 5'd2;
    localparam logic [4:0] CMD_SUB    = 5'd3;
    localparam logic [4:0] CMD_LT     = 5'd4;
    localparam logic [4:0] CMD_EQ     = 5'd5;
    localparam logic [4:0] CMD_GT     = 5'd6;
    localparam logic [4:0] CMD_QDUP   = 5'd7;
    localparam logic [4:0] CMD_FETCH  = 5'd8;
    localparam logic [4:0] CMD_AND    = 5'd9;
    localparam logic [4:0] CMD_CSTORE = 5'd10;
    localparam logic [4:0] CMD_CFETCH = 5'd11;
    localparam logic [4:0] CMD_DEPTH  = 5'd12;
    localparam logic [4:0] CMD_DROP   = 5'd13;
    localparam logic [4:0] CMD_DUP    = 5'd14;
    localparam logic [4:0] CMD_INVERT = 5'd15;
    localparam logic [4:0] CMD_LSHIFT = 5'd16;
    localparam logic [4:0] CMD_NEGATE = 5'd17;
    localparam logic [4:0] CMD_OR     = 5'd18;
    localparam logic [4:0] CMD_OVER   = 5'd19;
    localparam logic [4:0] CMD_ROT    = 5'd20;
    localparam logic [4:0] CMD_RSHIFT = 5'd21;
    localparam logic [4:0] CMD_SWAP   = 5'd22;
    localparam logic [4:0] CMD_XOR    = 5'd23;
    localparam logic [4:0] CMD_LIT    = 5'd24;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic [4:0]  command;
        logic [31:0] literal;
    } req_t;

    typedef struct packed {
        logic [31:0] top_value;
        logic [6:0]  item_count;
        logic [1:0]  status;
    } rsp_t;

    // items a word needs on the stack
    function automatic logic [1:0] need_of(input logic [4:0] cmd);
        logic [1:0] n;
        case (cmd)
            CMD_ROT: n = 2'd3;
            CMD_QDUP, CMD_FETCH, CMD_CFETCH, CMD_DROP, CMD_DUP, CMD_INVERT,
            CMD_NEGATE: n = 2'd1;
            CMD_STORE, CMD_MUL, CMD_ADD, CMD_SUB, CMD_LT, CMD_EQ, CMD_GT,
            CMD_AND, CMD_CSTORE, CMD_LSHIFT, CMD_OR, CMD_OVER, CMD_RSHIFT,
            CMD_SWAP, CMD_XOR: n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

/* design/smcw_alu.sv */
`timescale 1ns / 1ps
module smcw_alu #(
    parameter int CELL_BITS = 32
) (
    input  logic [4:0]           cmd,
    input  logic [CELL_BITS-1:0] a,
    input  logic [CELL_BITS-1:0] b,
    output logic [CELL_BITS-1:0] r
);

    logic big_shift;

    assign big_shift = (b >= CELL_BITS'(CELL_BITS));

    always_comb
    begin
        case (cmd)
            smcw_pkg::CMD_ADD:    r = a + b;
            smcw_pkg::CMD_SUB:    r = a - b;
            smcw_pkg::CMD_LT:     r = ($signed(a) < $signed(b)) ? '1 : '0;
            smcw_pkg::CMD_EQ:     r = (a == b) ? '1 : '0;
            smcw_pkg::CMD_GT:     r = ($signed(b) < $signed(a)) ? '1 : '0;
            smcw_pkg::CMD_AND:    r = a & b;
            smcw_pkg::CMD_OR:     r = a | b;
            smcw_pkg::CMD_XOR:    r = a ^ b;
            smcw_pkg::CMD_LSHIFT: r = big_shift ? '0 : (a << b);
            smcw_pkg::CMD_RSHIFT: r = big_shift ? '0 : (a >> b);
            default:              r = '0;
        endcase
    end

endmodule

/* design/stack_machine_core_words.sv */
`timescale 1ns / 1ps
// sequence: a request is accepted in idle, the execute state registers the result once the
// output is free; rot adds a state (two writes on the single stack memory write port),
// multiply a state of three half-width partial products through one shared multiplier
// throughput: one word at a time, the next request is taken once the result is registered
// reset: asynchronous active-low; after reset a clearing pass writes every cell of
// the data memory to zero, during which no request is accepted
module stack_machine_core_words #(
    parameter int CELL_BITS     = 32,
    parameter int STACK_ENTRIES = 64,
    parameter int MEM_CELLS     = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  smcw_pkg::req_t   cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output smcw_pkg::rsp_t   res
);

`include "stack_machine_core_words_assert.svh"

    localparam int CW        = $clog2(STACK_ENTRIES + 2);
    localparam int SAW       = $clog2(STACK_ENTRIES);
    localparam int MAW       = $clog2(MEM_CELLS);
    localparam int LANE_BITS = $clog2(CELL_BITS / 8);
    localparam int HALF      = CELL_BITS / 2;
    localparam logic [1:0] MulLast = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_MUL   = 5'b01000,
        S_ROT2  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CELL_BITS-1:0] top_reg;
    logic [CW-1:0]        count_reg;
    logic [4:0]           op_reg;
    logic [31:0]          lit_reg;
    logic [MAW-1:0]       clr_reg;
    logic [1:0]           step_reg, step_next;
    logic [CELL_BITS-1:0] acc_reg, acc_next;
    logic                 res_valid_reg;
    smcw_pkg::rsp_t       res_reg;

    // stack store and data memory, reads registered at accept
    logic [CELL_BITS-1:0] stk_mem [STACK_ENTRIES];
    logic [CELL_BITS-1:0] dmem    [MEM_CELLS];
    logic [CELL_BITS-1:0] s_rd_reg, x_rd_reg, dm_rd_reg;

    logic                 accept, out_free, commit;
    logic                 stk_we, dm_we;
    logic [SAW-1:0]       stk_wa;
    logic [CELL_BITS-1:0] stk_wd, dm_wd;
    logic [MAW-1:0]       dm_wa, dm_idx;
    logic [SAW-1:0]       a1, a2, a3;
    logic [63:0]          t_wide;
    logic [LANE_BITS-1:0] lane;
    logic [CELL_BITS-1:0] byte_mask, merged, byte_rd, alu_r;
    logic [CELL_BITS-1:0] fin_top;
    logic [CW-1:0]        fin_cnt;
    logic [1:0]           fin_status, status;
    logic                 known, grows, do_op;
    logic [HALF-1:0]      mul_a, mul_b;
    logic [CELL_BITS-1:0] prod;
    logic [CW-1:0]        cm1, cm2, cm3;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // addresses all come from committed state, so reads issued at accept are current
    assign cm1    = count_reg - CW'(1);
    assign cm2    = count_reg - CW'(2);
    assign cm3    = count_reg - CW'(3);
    assign a1     = cm1[SAW-1:0];
    assign a2     = cm2[SAW-1:0];
    assign a3     = cm3[SAW-1:0];
    assign t_wide = 64'(top_reg);
    assign dm_idx = t_wide[LANE_BITS +: MAW];
    assign lane   = top_reg[LANE_BITS-1:0];

    // byte lane access, lane 0 least significant
    assign byte_mask = CELL_BITS'(8'hFF) << {lane, 3'b000};
    assign merged    = (dm_rd_reg & ~byte_mask) | (CELL_BITS'(s_rd_reg[7:0]) << {lane, 3'b000});
    assign byte_rd   = CELL_BITS'(8'(dm_rd_reg >> {lane, 3'b000}));

    smcw_alu #(
        .CELL_BITS (CELL_BITS)
    ) u_alu (
        .cmd (op_reg),
        .a   (s_rd_reg),
        .b   (top_reg),
        .r   (alu_r)
    );

    // shared half-width multiplier: lo*lo, hi*lo, lo*hi
    assign mul_a = (step_reg == 2'd1) ? s_rd_reg[CELL_BITS-1:HALF] : s_rd_reg[HALF-1:0];
    assign mul_b = (step_reg == MulLast) ? top_reg[CELL_BITS-1:HALF] : top_reg[HALF-1:0];
    assign prod  = CELL_BITS'(mul_a) * CELL_BITS'(mul_b);

    // stack check
    always_comb
    begin
        known = (op_reg <= smcw_pkg::CMD_LIT);
        grows = (op_reg == smcw_pkg::CMD_DEPTH) || (op_reg == smcw_pkg::CMD_DUP) ||
                (op_reg == smcw_pkg::CMD_OVER) || (op_reg == smcw_pkg::CMD_LIT) ||
                ((op_reg == smcw_pkg::CMD_QDUP) && (top_reg != '0));
        if (known && (count_reg < CW'(smcw_pkg::need_of(op_reg))))
            status = smcw_pkg::ST_UNDERFLOW;
        else if (known && grows && (count_reg > CW'(STACK_ENTRIES)))
            status = smcw_pkg::ST_OVERFLOW;
        else
            status = smcw_pkg::ST_OK;
        do_op = known && (status == smcw_pkg::ST_OK);
    end

    // sequencer and word execution
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        commit     = 1'b0;
        fin_top    = top_reg;
        fin_cnt    = count_reg;
        fin_status = status;
        stk_we     = 1'b0;
        stk_wa     = a1;
        stk_wd     = top_reg;
        dm_we      = 1'b0;
        dm_wa      = dm_idx;
        dm_wd      = s_rd_reg;
        case (state_reg)
            S_CLEAR:
            begin
                dm_we = 1'b1;
                dm_wa = clr_reg;
                dm_wd = '0;
                if (clr_reg == MAW'(MEM_CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (do_op && (op_reg == smcw_pkg::CMD_MUL))
                begin
                    step_next  = 2'd0;
                    state_next = S_MUL;
                end
                else if (do_op && (op_reg == smcw_pkg::CMD_ROT))
                begin
                    // upper write of rot; the lower one follows
                    stk_we     = 1'b1;
                    stk_wa     = a2;
                    stk_wd     = top_reg;
                    state_next = S_ROT2;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    if (do_op)
                    begin
                        case (op_reg)
                            smcw_pkg::CMD_STORE, smcw_pkg::CMD_CSTORE:
                            begin
                                dm_we   = 1'b1;
                                dm_wd   = (op_reg == smcw_pkg::CMD_STORE) ? s_rd_reg : merged;
                                fin_cnt = cm2;
                                fin_top = (count_reg >= CW'(3)) ? x_rd_reg : '0;
                            end
                            smcw_pkg::CMD_QDUP, smcw_pkg::CMD_DUP:
                            begin
                                if (top_reg != '0 || op_reg == smcw_pkg::CMD_DUP)
                                begin
                                    stk_we  = 1'b1;
                                    fin_cnt = count_reg + CW'(1);
                                end
                            end
                            smcw_pkg::CMD_FETCH:  fin_top = dm_rd_reg;
                            smcw_pkg::CMD_CFETCH: fin_top = byte_rd;
                            smcw_pkg::CMD_DEPTH:
                            begin
                                stk_we  = (count_reg != '0);
                                fin_top = CELL_BITS'(count_reg);
                                fin_cnt = count_reg + CW'(1);
                            end
                            smcw_pkg::CMD_DROP:
                            begin
                                fin_cnt = cm1;
                                fin_top = (count_reg >= CW'(2)) ? s_rd_reg : '0;
                            end
                            smcw_pkg::CMD_INVERT: fin_top = ~top_reg;
                            smcw_pkg::CMD_NEGATE: fin_top = '0 - top_reg;
                            smcw_pkg::CMD_OVER:
                            begin
                                stk_we  = 1'b1;
                                fin_top = s_rd_reg;
                                fin_cnt = count_reg + CW'(1);
                            end
                            smcw_pkg::CMD_SWAP:
                            begin
                                stk_we  = 1'b1;
                                stk_wa  = a2;
                                fin_top = s_rd_reg;
                            end
                            smcw_pkg::CMD_LIT:
                            begin
                                stk_we  = (count_reg != '0);
                                fin_top = CELL_BITS'(lit_reg);
                                fin_cnt = count_reg + CW'(1);
                            end
                            default:
                            begin
                                // two-operand words through the alu
                                fin_top = alu_r;
                                fin_cnt = cm1;
                            end
                        endcase
                    end
                end
            end
            S_MUL:
            begin
                if (step_reg == 2'd0)
                begin
                    acc_next  = prod;
                    step_next = 2'd1;
                end
                else if (step_reg != MulLast)
                begin
                    acc_next  = acc_reg + (prod << HALF);
                    step_next = MulLast;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    fin_top    = acc_reg + (prod << HALF);
                    fin_cnt    = cm1;
                    state_next = S_IDLE;
                end
            end
            S_ROT2:
            begin
                if (out_free)
                begin
                    stk_we     = 1'b1;
                    stk_wa     = a3;
                    stk_wd     = s_rd_reg;
                    commit     = 1'b1;
                    fin_top    = x_rd_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_wa] <= stk_wd;
        if (accept)
        begin
            s_rd_reg <= stk_mem[a2];
            x_rd_reg <= stk_mem[a3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
            dmem[dm_wa] <= dm_wd;
        if (accept)
            dm_rd_reg <= dmem[dm_idx];
    end

    // request payload and multiply accumulator
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.command;
            lit_reg <= cmd.literal;
        end
        acc_reg <= acc_next;
        if (commit)
        begin
            res_reg.top_value  <= (fin_cnt != '0) ? 32'(fin_top) : 32'd0;
            res_reg.item_count <= 7'(fin_cnt);
            res_reg.status     <= fin_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            top_reg       <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + MAW'(1);
            if (commit)
            begin
                top_reg   <= fin_top;
                count_reg <= fin_cnt;
            end
            if (commit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // checks
    `SMCW_ASSERT_ALWAYS(a_count_range, count_reg <= CW'(STACK_ENTRIES + 1), "stack count out of range")
    `SMCW_ASSERT_IMPLY(a_empty_top, count_reg == '0, top_reg == '0, "top not zero on empty stack")
    `SMCW_ASSERT_NEXT(a_no_early_commit, accept, $stable(count_reg) && $stable(top_reg), "state changed at accept")
    `SMCW_ASSERT_IMPLY(a_clear_blocks, state_reg == S_CLEAR, !cmd_ready && !res_valid_reg, "request during clearing pass")

endmodule

/* verif/stack_machine_core_words_checker.sv */
`timescale 1ns / 1ps
module stack_machine_core_words_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd_ready,
    input  smcw_pkg::req_t  cmd,
    input  logic            res_valid,
    input  logic            res_ready,
    input  smcw_pkg::rsp_t  res,
    output int              mismatches,
    output int              pending
);

    localparam int DEPTH_MAX = 64;
    localparam int CELLS     = 1024;

    logic [31:0]    tos;
    logic [31:0]    below [DEPTH_MAX];
    logic [6:0]     depth;
    logic [31:0]    mem [CELLS];
    smcw_pkg::rsp_t expected_q[$];

    function automatic logic [1:0] words_needed(logic [4:0] c);
        case (c)
            smcw_pkg::CMD_ROT: return 2'd3;
            smcw_pkg::CMD_QDUP, smcw_pkg::CMD_FETCH, smcw_pkg::CMD_CFETCH,
            smcw_pkg::CMD_DROP, smcw_pkg::CMD_DUP, smcw_pkg::CMD_INVERT,
            smcw_pkg::CMD_NEGATE: return 2'd1;
            smcw_pkg::CMD_DEPTH, smcw_pkg::CMD_LIT: return 2'd0;
            default: return (c > smcw_pkg::CMD_LIT) ? 2'd0 : 2'd2;
        endcase
    endfunction

    // apply one word to the model state and queue its result
    task automatic execute_word(smcw_pkg::req_t r);
        logic [31:0] t, s, x1, v;
        logic [6:0]  n;
        logic [1:0]  st;
        logic        grows;
        int          ci, sh;
        t = tos;
        n = depth;
        s = '0;
        v = '0;
        st = smcw_pkg::ST_OK;
        grows = (r.command == smcw_pkg::CMD_DEPTH || r.command == smcw_pkg::CMD_DUP ||
                 r.command == smcw_pkg::CMD_OVER || r.command == smcw_pkg::CMD_LIT ||
                 (r.command == smcw_pkg::CMD_QDUP && t != 0));
        if (r.command <= smcw_pkg::CMD_LIT)
        begin
            if (n < 7'(words_needed(r.command)))
                st = smcw_pkg::ST_UNDERFLOW;
            else if (grows && n > 7'(DEPTH_MAX))
                st = smcw_pkg::ST_OVERFLOW;
        end
        if (st == smcw_pkg::ST_OK && r.command <= smcw_pkg::CMD_LIT)
        begin
            if (n >= 7'd2)
                s = below[n-2];
            ci = int'((t >> 2) % CELLS);
            sh = 8 * int'(t[1:0]);
            case (r.command)
                smcw_pkg::CMD_STORE, smcw_pkg::CMD_CSTORE:
                begin
                    if (r.command == smcw_pkg::CMD_STORE)
                        mem[ci] = s;
                    else
                        mem[ci] = (mem[ci] & ~(32'hff << sh)) | ((s & 32'hff) << sh);
                    n = n - 7'd2;
                    t = (n >= 7'd1) ? below[n-1] : '0;
                end
                smcw_pkg::CMD_MUL, smcw_pkg::CMD_ADD, smcw_pkg::CMD_SUB, smcw_pkg::CMD_LT,
                smcw_pkg::CMD_EQ, smcw_pkg::CMD_GT, smcw_pkg::CMD_AND, smcw_pkg::CMD_LSHIFT,
                smcw_pkg::CMD_OR, smcw_pkg::CMD_RSHIFT, smcw_pkg::CMD_XOR:
                begin
                    case (r.command)
                        smcw_pkg::CMD_MUL:    v = s * t;
                        smcw_pkg::CMD_ADD:    v = s + t;
                        smcw_pkg::CMD_SUB:    v = s - t;
                        smcw_pkg::CMD_LT:     v = ($signed(s) < $signed(t)) ? '1 : '0;
                        smcw_pkg::CMD_EQ:     v = (s == t) ? '1 : '0;
                        smcw_pkg::CMD_GT:     v = ($signed(t) < $signed(s)) ? '1 : '0;
                        smcw_pkg::CMD_AND:    v = s & t;
                        smcw_pkg::CMD_LSHIFT: v = (t >= 32) ? '0 : s << t;
                        smcw_pkg::CMD_OR:     v = s | t;
                        smcw_pkg::CMD_RSHIFT: v = (t >= 32) ? '0 : s >> t;
                        default:              v = s ^ t;
                    endcase
                    n = n - 7'd1;
                    t = v;
                end
                smcw_pkg::CMD_QDUP, smcw_pkg::CMD_DUP:
                begin
                    if (t != 0 || r.command == smcw_pkg::CMD_DUP)
                    begin
                        below[n-1] = t;
                        n = n + 7'd1;
                    end
                end
                smcw_pkg::CMD_FETCH:  t = mem[ci];
                smcw_pkg::CMD_CFETCH: t = (mem[ci] >> sh) & 32'hff;
                smcw_pkg::CMD_DEPTH:
                begin
                    if (n >= 7'd1)
                        below[n-1] = t;
                    t = 32'(n);
                    n = n + 7'd1;
                end
                smcw_pkg::CMD_DROP:
                begin
                    n = n - 7'd1;
                    t = (n >= 7'd1) ? below[n-1] : '0;
                end
                smcw_pkg::CMD_INVERT: t = ~t;
                smcw_pkg::CMD_NEGATE: t = -t;
                smcw_pkg::CMD_OVER:
                begin
                    below[n-1] = t;
                    t = s;
                    n = n + 7'd1;
                end
                smcw_pkg::CMD_ROT:
                begin
                    x1 = below[n-3];
                    below[n-3] = s;
                    below[n-2] = t;
                    t = x1;
                end
                smcw_pkg::CMD_SWAP:
                begin
                    below[n-2] = t;
                    t = s;
                end
                default:
                begin
                    if (n >= 7'd1)
                        below[n-1] = t;
                    t = r.literal;
                    n = n + 7'd1;
                end
            endcase
            tos = t;
            depth = n;
        end
        expected_q.push_back('{top_value: (depth != 0) ? tos : 32'd0,
                               item_count: depth, status: st});
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tos = '0;
            depth = '0;
            mismatches = 0;
            expected_q.delete();
            for (int i = 0; i < CELLS; i++)
                mem[i] = '0;
            for (int i = 0; i < DEPTH_MAX; i++)
                below[i] = '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", res);
                end
                else if (res !== expected_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp top %h cnt %0d st %0d, got top %h cnt %0d st %0d",
                                 expected_q[0].top_value, expected_q[0].item_count,
                                 expected_q[0].status, res.top_value, res.item_count,
                                 res.status);
                    void'(expected_q.pop_front());
                end
                else
                    void'(expected_q.pop_front());
            end
            if (cmd_valid && cmd_ready)
                execute_word(cmd);
        end
    end
endmodule

/* verif/stack_machine_core_words_tb.sv */
`timescale 1ns / 1ps
module stack_machine_core_words_tb;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_ready;
    smcw_pkg::req_t cmd;
    logic           res_valid;
    logic           res_ready;
    smcw_pkg::rsp_t res;
    int             mismatches;
    int             pending;

    // idle percentages for each side, changed between phases
    int   send_idle_pct;
    int   recv_idle_pct;
    // receiver hold-off in cycles, served by the receiver process
    int   recv_hold_cycles;

    stack_machine_core_words dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    stack_machine_core_words_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // generous fixed limit: clearing pass plus ~1100 words under heavy stalls
    initial
    begin
        #20ms;
        $display("stack_machine_core_words test failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        res_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (recv_hold_cycles > 0)
            begin
                res_ready <= 0;
                recv_hold_cycles--;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one request and wait until it is taken; random idle before it
    task automatic send_word(logic [4:0] c, logic [31:0] lit);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= '{command: c, literal: lit};
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // mostly well-formed traffic: keep the stack populated with useful
    // values, pick addresses and shift amounts from small ranges often
    task automatic random_words(int count);
        logic [4:0]  c;
        logic [31:0] lit;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2: c = smcw_pkg::CMD_LIT;
                3:       c = 5'($urandom_range(31));
                default: c = 5'($urandom_range(23));
            endcase
            case ($urandom_range(5))
                0:       lit = $urandom_range(64);
                1:       lit = $urandom_range(4095);
                2:       lit = {1'($urandom_range(1)), 31'd0} | $urandom_range(3);
                3:       lit = 32'hffff_ffff - $urandom_range(3);
                default: lit = $urandom;
            endcase
            send_word(c, lit);
        end
    endtask

    initial
    begin
        rst_n = 0;
        cmd_valid = 0;
        cmd = '0;
        send_idle_pct = 37;
        recv_idle_pct = 83;
        recv_hold_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;

        // directed: underflows on empty stack, every word, edge values
        send_word(smcw_pkg::CMD_DROP, 0);
        send_word(smcw_pkg::CMD_ROT, 0);
        send_word(smcw_pkg::CMD_ADD, 0);
        send_word(smcw_pkg::CMD_LIT, 32'hffff_ffff);
        send_word(smcw_pkg::CMD_LIT, 32'h8000_0000);
        send_word(smcw_pkg::CMD_LT, 0);
        send_word(smcw_pkg::CMD_QDUP, 0);
        send_word(smcw_pkg::CMD_LIT, 32'd0);
        send_word(smcw_pkg::CMD_QDUP, 0);
        send_word(smcw_pkg::CMD_LIT, 32'd33);
        send_word(smcw_pkg::CMD_LSHIFT, 0);
        send_word(smcw_pkg::CMD_LIT, 32'h1234_5678);
        send_word(smcw_pkg::CMD_LIT, 32'd7);
        send_word(smcw_pkg::CMD_STORE, 0);
        send_word(smcw_pkg::CMD_LIT, 32'd5);
        send_word(smcw_pkg::CMD_CFETCH, 0);
        send_word(smcw_pkg::CMD_DEPTH, 0);
        send_word(smcw_pkg::CMD_ROT, 0);
        // unused code, does nothing
        send_word(5'd31, 0);
        for (int c = 0; c <= 24; c++)
            send_word(c[4:0], $urandom);

        // fill the stack to overflow, then drain with underflow at the bottom
        for (int i = 0; i < 68; i++)
            send_word(smcw_pkg::CMD_LIT, $urandom);
        send_word(smcw_pkg::CMD_DUP, 0);
        send_word(smcw_pkg::CMD_OVER, 0);
        for (int i = 0; i < 67; i++)
            send_word(smcw_pkg::CMD_DROP, 0);

        random_words(320);
        wait_drained();

        send_idle_pct = 83;
        recv_idle_pct = 37;
        random_words(320);

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 300;
        random_words(40);
        wait_drained();
        random_words(190);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("stack_machine_core_words test passed");
        else
            $display("stack_machine_core_words test failed");
        $finish;
    end
endmodule
